// ===== design/brf_pkg.sv =====
// Shared constants, codes and types for the byte ring FIFO.
package brf_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CAP_W     = 11;
    localparam int MAX_BLOCK = 8;
    localparam int CNT_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int BLOCK_W   = MAX_BLOCK * BYTE_W;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_PULL   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_STATUS = 2'd3;

    typedef struct packed {
        logic load;
        logic shift;
    } shift_ctrl_t;

endpackage

// ===== design/brf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/brf_shift.sv =====
// Byte-serial shift register: unloads push data and assembles pulled data.
module brf_shift
    import brf_pkg::*;
(
    input  logic               clk,
    input  shift_ctrl_t        ctrl,
    input  logic [BLOCK_W-1:0] load_word,
    input  logic [BYTE_W-1:0]  byte_in,
    output logic [BYTE_W-1:0]  byte_out,
    output logic [BLOCK_W-1:0] word
);

    logic [BLOCK_W-1:0] sh_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sh_reg <= load_word;
        end
        else if (ctrl.shift)
        begin
            sh_reg <= {byte_in, sh_reg[BLOCK_W-1:BYTE_W]};
        end
    end

    assign byte_out = sh_reg[BYTE_W-1:0];
    assign word     = sh_reg;

endmodule

// ===== design/byte_ring_fifo_block_push_pull.sv =====
// Byte ring FIFO with block push and pull, one byte moved per cycle.
// A push shifts its bytes from the shift register into the store; a pull reads the store and shifts
// each byte into the shift register over every byte slot of the block; clear, status and refused items skip both.
// One word in process at a time; next word accepted the cycle after the result is loaded;
// a result still held in the output register stalls this.
// Reset: both pointers zero, ring empty, capacity 1024; store contents undefined.
module byte_ring_fifo_block_push_pull
    import brf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [71:0]       s_tdata,  // byte_count[3:0], push_bytes[67:4], zero pad
    input  logic [1:0]        s_tuser,  // cmd[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,  // pull_bytes[63:0], moved_count[67:64],
                                        // used_bytes[78:68], free_bytes[89:79], zero pad
    output logic              m_tuser,  // accepted
    input  logic              cfg_wen,
    input  logic [CAP_W-1:0]  cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_XFER = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK);

    logic [1:0]         state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               go_reg, go_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]  wp_reg, wp_next;
    logic [ADDR_W-1:0]  rp_reg, rp_next;
    logic [CAP_W-1:0]   used_reg, used_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic               m_valid_reg, m_valid_next;
    logic               acc_reg, acc_next;
    logic [BLOCK_W-1:0] pull_reg, pull_next;
    logic [CNT_W-1:0]   moved_reg, moved_next;
    logic [CAP_W-1:0]   uout_reg, uout_next;
    logic [CAP_W-1:0]   fout_reg, fout_next;

    logic [1:0]         in_cmd;
    logic [CNT_W-1:0]   in_cnt;
    logic [BLOCK_W-1:0] in_data;
    logic               in_acc;
    logic [CAP_W-1:0]   space;
    logic [CAP_W-1:0]   used_new;
    logic [CAP_W-1:0]   wp_inc, rp_inc;

    shift_ctrl_t        sh_ctrl;
    logic [BLOCK_W-1:0] sh_load;
    logic [BYTE_W-1:0]  sh_in, sh_out;
    logic [BLOCK_W-1:0] sh_word;

    logic               ram_we, ram_re;
    logic [BYTE_W-1:0]  ram_rdata;

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sh_out),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    brf_shift u_shift (
        .clk       (clk),
        .ctrl      (sh_ctrl),
        .load_word (sh_load),
        .byte_in   (sh_in),
        .byte_out  (sh_out),
        .word      (sh_word)
    );

    assign in_cmd  = s_tuser;
    assign in_cnt  = s_tdata[CNT_W-1:0];
    assign in_data = s_tdata[CNT_W+BLOCK_W-1:CNT_W];

    assign space  = cap_reg - used_reg;
    assign wp_inc = {1'b0, wp_reg} + CAP_W'(1);
    assign rp_inc = {1'b0, rp_reg} + CAP_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = acc_reg;
    assign m_tdata  = {6'd0, fout_reg, uout_reg, moved_reg, pull_reg};

    always_comb
    begin
        case (in_cmd)
            CMD_PUSH: in_acc = (in_cnt <= CNT_MAX) && ({7'd0, in_cnt} < space);
            CMD_PULL: in_acc = (in_cnt <= CNT_MAX) && ({7'd0, in_cnt} <= used_reg);
            default:  in_acc = 1'b1;
        endcase
    end

    always_comb
    begin
        if (!go_reg)
        begin
            used_new = used_reg;
        end
        else if (cmd_reg == CMD_PUSH)
        begin
            used_new = used_reg + {7'd0, cnt_reg};
        end
        else if (cmd_reg == CMD_PULL)
        begin
            used_new = used_reg - {7'd0, cnt_reg};
        end
        else
        begin
            used_new = used_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        go_next      = go_reg;
        idx_next     = idx_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        used_next    = used_reg;
        cap_next     = cap_reg;
        m_valid_next = m_valid_reg;
        acc_next     = acc_reg;
        pull_next    = pull_reg;
        moved_next   = moved_reg;
        uout_next    = uout_reg;
        fout_next    = fout_reg;
        sh_ctrl      = '0;
        sh_load      = in_data;
        sh_in        = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cfg_wen)
        begin
            if (cfg_wdata < CAP_MIN)
            begin
                cap_next = CAP_MIN;
            end
            else if (cfg_wdata > CAP_MAX)
            begin
                cap_next = CAP_MAX;
            end
            else
            begin
                cap_next = cfg_wdata;
            end
            wp_next   = '0;
            rp_next   = '0;
            used_next = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next     = in_cmd;
                    cnt_next     = in_cnt;
                    go_next      = in_acc;
                    idx_next     = '0;
                    sh_ctrl.load = 1'b1;
                    if (in_cmd != CMD_PUSH)
                    begin
                        sh_load = '0;
                    end
                    if (in_cmd == CMD_CLEAR)
                    begin
                        wp_next   = '0;
                        rp_next   = '0;
                        used_next = '0;
                    end
                    if (in_acc && (in_cmd == CMD_PULL))
                    begin
                        state_next = ST_XFER;
                    end
                    else if (in_acc && (in_cmd == CMD_PUSH) && (in_cnt != '0))
                    begin
                        state_next = ST_XFER;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_XFER:
            begin
                idx_next = idx_reg + CNT_W'(1);
                if (cmd_reg == CMD_PUSH)
                begin
                    ram_we        = 1'b1;
                    sh_ctrl.shift = 1'b1;
                    wp_next       = (wp_inc >= cap_reg) ? '0 : wp_inc[ADDR_W-1:0];
                    if (idx_next == cnt_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    if (idx_reg < cnt_reg)
                    begin
                        ram_re  = 1'b1;
                        rp_next = (rp_inc >= cap_reg) ? '0 : rp_inc[ADDR_W-1:0];
                    end
                    if (idx_reg != '0)
                    begin
                        sh_ctrl.shift = 1'b1;
                        sh_in         = (idx_reg <= cnt_reg) ? ram_rdata : '0;
                    end
                    if (idx_reg == CNT_MAX)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    acc_next     = go_reg;
                    pull_next    = (cmd_reg == CMD_PULL) ? sh_word : '0;
                    moved_next   = (go_reg && ((cmd_reg == CMD_PUSH) || (cmd_reg == CMD_PULL)))
                                   ? cnt_reg : '0;
                    uout_next    = used_new;
                    fout_next    = cap_reg - used_new;
                    used_next    = used_new;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmd_reg     <= CMD_STATUS;
            cnt_reg     <= '0;
            go_reg      <= 1'b0;
            idx_reg     <= '0;
            wp_reg      <= '0;
            rp_reg      <= '0;
            used_reg    <= '0;
            cap_reg     <= CAP_MAX;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            cnt_reg     <= cnt_next;
            go_reg      <= go_next;
            idx_reg     <= idx_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            used_reg    <= used_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        pull_reg  <= pull_next;
        moved_reg <= moved_next;
        uout_reg  <= uout_next;
        fout_reg  <= fout_next;
    end

endmodule

// ===== bench/tb_byte_ring_fifo_block_push_pull.sv =====
// Self-checking testbench for the byte ring FIFO with block push and pull.
`timescale 1ns / 100ps

import brf_pkg::*;

typedef struct packed {
    logic               accepted;
    logic [BLOCK_W-1:0] pull_bytes;
    logic [CNT_W-1:0]   moved;
    logic [CAP_W-1:0]   used_b;
    logic [CAP_W-1:0]   free_b;
} ring_result_t;

class ring_scoreboard;
    logic [BYTE_W-1:0] store [DEPTH];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    int unsigned       cap;
    ring_result_t      expected_q [$];
    int unsigned       mismatches;
    int unsigned       words_in;
    int unsigned       push_ok;
    int unsigned       pull_ok;
    int unsigned       refused;
    int unsigned       wraps;

    function new();
        wr_ptr = 0;
        rd_ptr = 0;
        cap = DEPTH;
    endfunction

    function int unsigned fill_level();
        if (wr_ptr >= rd_ptr)
            return wr_ptr - rd_ptr;
        return wr_ptr + cap - rd_ptr;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function int unsigned step_ptr(int unsigned p);
        if (p + 1 >= cap)
        begin
            wraps++;
            return 0;
        end
        return p + 1;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
        int unsigned v;
        v = value;
        if (v < 2)
            v = 2;
        if (v > DEPTH)
            v = DEPTH;
        cap = v;
        wr_ptr = 0;
        rd_ptr = 0;
    endfunction

    function void note_input(logic [1:0] cmd, logic [CNT_W-1:0] cnt, logic [BLOCK_W-1:0] data);
        ring_result_t r;
        int unsigned  n;
        n = cnt;
        r = '0;
        words_in++;
        case (cmd)
            CMD_PUSH:
                if (n <= MAX_BLOCK && n < cap - fill_level())
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        store[wr_ptr] = data[8*i +: 8];
                        wr_ptr = step_ptr(wr_ptr);
                    end
                    r.accepted = 1'b1;
                    r.moved = cnt;
                    push_ok++;
                end
                else
                    refused++;
            CMD_PULL:
                if (n <= MAX_BLOCK && n <= fill_level())
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        r.pull_bytes[8*i +: 8] = store[rd_ptr];
                        rd_ptr = step_ptr(rd_ptr);
                    end
                    r.accepted = 1'b1;
                    r.moved = cnt;
                    pull_ok++;
                end
                else
                    refused++;
            CMD_CLEAR:
            begin
                wr_ptr = 0;
                rd_ptr = 0;
                r.accepted = 1'b1;
            end
            default:
                r.accepted = 1'b1;
        endcase
        r.used_b = CAP_W'(fill_level());
        r.free_b = CAP_W'(cap - fill_level());
        expected_q.push_back(r);
    endfunction

    function void check_result(logic accepted, logic [95:0] word);
        ring_result_t got;
        ring_result_t want;
        got.accepted = accepted;
        got.pull_bytes = word[63:0];
        got.moved = word[67:64];
        got.used_b = word[78:68];
        got.free_b = word[89:79];
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word %h acc=%0b", word, accepted);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp acc=%0b pull=%h moved=%0d used=%0d free=%0d | got acc=%0b pull=%h moved=%0d used=%0d free=%0d",
                         want.accepted, want.pull_bytes, want.moved, want.used_b, want.free_b,
                         got.accepted, got.pull_bytes, got.moved, got.used_b, got.free_b);
        end
    endfunction
endclass

module tb_byte_ring_fifo_block_push_pull;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 300;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [71:0]       s_tdata;   // byte_count[3:0], push_bytes[67:4], zero pad
    logic [1:0]        s_tuser;   // cmd[1:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [95:0]       m_tdata;   // pull_bytes, moved_count, used_bytes, free_bytes, zero pad
    logic              m_tuser;   // accepted
    logic              cfg_wen;
    logic [CAP_W-1:0]  cfg_wdata;

    ring_scoreboard sb;
    bit             idle_on;
    bit             hold_req;
    int unsigned    cycles;
    int unsigned    settings;

    byte_ring_fifo_block_push_pull u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_word(logic [1:0] cmd, logic [CNT_W-1:0] cnt, logic [BLOCK_W-1:0] data);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, data, cnt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(cmd, cnt, data);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_wen   <= 1'b1;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        sb.set_capacity(value);
        settings++;
    endtask

    task automatic random_word(int unsigned push_pct);
        int unsigned pick;
        int unsigned fill;
        logic [CNT_W-1:0] cnt;
        pick = $urandom_range(0, 99);
        fill = sb.fill_level();
        if (pick < push_pct)
        begin
            cnt = ($urandom_range(0, 1) == 0) ? CNT_W'(MAX_BLOCK) : CNT_W'($urandom_range(0, 8));
            send_word(CMD_PUSH, cnt, {$urandom, $urandom});
        end
        else if (pick < 88)
        begin
            if (fill > 0 && $urandom_range(0, 4) != 0)
                cnt = CNT_W'($urandom_range(0, (fill < MAX_BLOCK) ? fill : MAX_BLOCK));
            else
                cnt = CNT_W'($urandom_range(0, 8));
            send_word(CMD_PULL, cnt, {$urandom, $urandom});
        end
        else if (pick < 93)
            send_word(($urandom_range(0, 1) == 0) ? CMD_PUSH : CMD_PULL,
                      CNT_W'($urandom_range(9, 15)), {$urandom, $urandom});
        else if (pick < 98)
            send_word(CMD_STATUS, CNT_W'($urandom), {$urandom, $urandom});
        else
            send_word(CMD_CLEAR, CNT_W'($urandom), {$urandom, $urandom});
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 11);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0] cap_v;
        int unsigned      n_items;
        int unsigned      push_pct;

        sb = new();
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        settings  = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_STATUS;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset capacity
        send_word(CMD_STATUS, 4'd0, '0);
        send_word(CMD_PUSH, 4'd0, '1);
        send_word(CMD_PUSH, 4'd8, '1);
        send_word(CMD_PUSH, 4'd8, '0);
        send_word(CMD_PUSH, 4'd3, 64'hA5C3_0F1E_7788_9922);
        send_word(CMD_PUSH, 4'd9, '1);
        send_word(CMD_PUSH, 4'd15, '1);
        send_word(CMD_PULL, 4'd9, '0);
        send_word(CMD_PULL, 4'd0, '1);
        send_word(CMD_PULL, 4'd8, '0);
        send_word(CMD_PULL, 4'd8, '1);
        send_word(CMD_PULL, 4'd4, '0);
        send_word(CMD_PULL, 4'd3, '0);
        send_word(CMD_PUSH, 4'd5, 64'h0123_4567_89AB_CDEF);
        send_word(CMD_CLEAR, 4'd15, '1);
        send_word(CMD_PULL, 4'd1, '0);
        send_word(CMD_PUSH, 4'd4, 64'hFFFF_FFFF_DEAD_BEEF);

        // capacity write on a non-empty ring, below-minimum value
        write_capacity(11'd0);
        send_word(CMD_STATUS, 4'd0, '0);
        send_word(CMD_PUSH, 4'd1, 64'h5A);
        send_word(CMD_PUSH, 4'd1, 64'h3C);
        send_word(CMD_PUSH, 4'd0, '0);
        send_word(CMD_PULL, 4'd2, '0);
        send_word(CMD_PULL, 4'd1, '0);
        send_word(CMD_PULL, 4'd0, '0);

        for (int p = 0; p < 11; p++)
        begin
            case (p)
                0:  begin cap_v = 11'd1;    n_items = 50;  end
                1:  begin cap_v = 11'd3;    n_items = 60;  end
                2:  begin cap_v = 11'd9;    n_items = 60;  end
                3:  begin cap_v = 11'd2047; n_items = 300; end
                4:  begin cap_v = 11'd17;   n_items = 60;  end
                5:  begin cap_v = 11'd5;    n_items = 50;  end
                6:  begin cap_v = 11'd64;   n_items = 60;  end
                7:  begin cap_v = 11'd1025; n_items = 60;  end
                8:  begin cap_v = 11'd2;    n_items = 40;  end
                9:  begin cap_v = CAP_W'($urandom_range(2, 200)); n_items = 60; end
                default: begin cap_v = 11'd1024; n_items = 60; end
            endcase
            write_capacity(cap_v);
            idle_on = (p != 5 && p != 10);
            for (int i = 0; i < n_items; i++)
            begin
                if (p == 3)
                    push_pct = (i < 200) ? 90 : 25;
                else
                    push_pct = 45;
                if (p == 3 && i == 40)
                    hold_req = 1'b1;
                if (p == 1 && i == 25)
                    wait_drained();
                random_word(push_pct);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("%0d words over %0d capacity settings, %0d cycles", sb.words_in, settings, cycles);
        $display("pushes %0d, pulls %0d, refused %0d, pointer wraps %0d",
                 sb.push_ok, sb.pull_ok, sb.refused, sb.wraps);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
